/* rtl/rv64ex_pkg.sv */
// ============================================================================
// rv64ex_pkg - shared definitions of the RV64IM execute block
// Opcodes, CSR addresses, status masks, result codes and the request type
// of the iterative multiply/divide unit.
// ============================================================================
`default_nettype none

package rv64ex_pkg;

	localparam int unsigned XLEN = 64;

	// Major opcodes
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP32   = 7'h3B;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_CUSTOM3 = 7'h7B;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_BRKALT = 7'h6B;

	// Exact instruction words
	localparam logic [31:0] WORD_EBREAK  = 32'h0010_0073;
	localparam logic [31:0] WORD_ECALL   = 32'h0000_0073;
	localparam logic [31:0] WORD_MRET    = 32'h3020_0073;
	localparam logic [31:0] WORD_FENCE_I = 32'h0000_100F;

	// funct7 codes
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	// Machine CSR addresses
	localparam logic [11:0] CSR_MTVEC    = 12'h305;
	localparam logic [11:0] CSR_MCAUSE   = 12'h342;
	localparam logic [11:0] CSR_MSTATUS  = 12'h300;
	localparam logic [11:0] CSR_MEPC     = 12'h341;
	localparam logic [11:0] CSR_MIE      = 12'h304;
	localparam logic [11:0] CSR_MIP      = 12'h344;
	localparam logic [11:0] CSR_MSCRATCH = 12'h340;

	// mstatus bits and masks
	localparam int unsigned ST_MIE_BIT  = 3;
	localparam int unsigned ST_MPIE_BIT = 7;
	localparam logic [63:0] ST_MPP_CLEAR = 64'hFFFF_FFFF_FFFF_E7FF;
	localparam logic [63:0] ST_MPP_SET   = 64'h0000_0000_0000_1800;
	localparam logic [63:0] ST_KEEP_MASK = 64'h7FFF_FFFA_0002_1888;

	// CSR operation codes, funct3 bits 1:0
	localparam logic [1:0] CSROP_RW = 2'd1;
	localparam logic [1:0] CSROP_RS = 2'd2;
	localparam logic [1:0] CSROP_RC = 2'd3;

	// Memory request kinds
	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_LOAD  = 2'd1;
	localparam logic [1:0] MEM_STORE = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EBREAK  = 2'd1;
	localparam logic [1:0] STAT_ILLEGAL = 2'd2;
	localparam logic [1:0] STAT_ECALL   = 2'd3;

	// Multiply/divide operations, in funct3 order
	typedef enum logic [2:0] {
		MD_MUL, MD_MULH, MD_MULHSU, MD_MULHU, MD_DIV, MD_DIVU, MD_REM, MD_REMU
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

	function automatic logic [63:0] sx32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

endpackage

`default_nettype wire

/* rtl/rv64ex_req_if.sv */
// ============================================================================
// rv64ex_req_if - instruction channel
// Valid/ready channel carrying one instruction and its operands.
// ============================================================================
`default_nettype none

interface rv64ex_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic [63:0] instr_pc;
	logic [63:0] rs1_value;
	logic [63:0] rs2_value;
	logic [63:0] a7_value;

	modport source (output valid, instruction, instr_pc, rs1_value, rs2_value, a7_value,
		input ready);
	modport sink (input valid, instruction, instr_pc, rs1_value, rs2_value, a7_value,
		output ready);
endinterface

`default_nettype wire

/* rtl/rv64ex_rsp_if.sv */
// ============================================================================
// rv64ex_rsp_if - result channel
// Valid/ready channel carrying one execution result.
// ============================================================================
`default_nettype none

interface rv64ex_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  rd_index;
	logic        rd_write;
	logic [63:0] rd_value;
	logic [63:0] next_pc;
	logic [1:0]  mem_kind;
	logic [1:0]  mem_size_log2;
	logic        load_signed;
	logic [63:0] mem_addr;
	logic [63:0] store_data;
	logic [1:0]  status;

	modport source (output valid, rd_index, rd_write, rd_value, next_pc, mem_kind,
		mem_size_log2, load_signed, mem_addr, store_data, status, input ready);
	modport sink (input valid, rd_index, rd_write, rd_value, next_pc, mem_kind,
		mem_size_log2, load_signed, mem_addr, store_data, status, output ready);
endinterface

`default_nettype wire

/* rtl/rv64ex_muldiv.sv */
// ============================================================================
// rv64ex_muldiv - iterative multiply/divide unit
// One bit per cycle: shift-add multiply and restoring divide, 64 steps.
// ============================================================================
`default_nettype none

module rv64ex_muldiv
	import rv64ex_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire md_req_t     req,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      result
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t      state_q;
	md_op_t      op_q;
	logic [63:0] a_q, b_q, dv_q, acc_q, lo_q;
	logic [5:0]  cnt_q;
	logic        na_q, nb_q;

	logic        is_div, sgn;
	logic [63:0] ma, mb;
	logic [64:0] msum, shifted, diff;

	assign is_div = (req.op == MD_DIV) || (req.op == MD_DIVU) || (req.op == MD_REM)
		|| (req.op == MD_REMU);
	assign sgn    = (req.op == MD_DIV) || (req.op == MD_REM);
	assign ma     = (sgn && a[63]) ? 64'd0 - a : a;
	assign mb     = (sgn && b[63]) ? 64'd0 - b : b;

	assign msum    = {1'b0, acc_q} + (lo_q[0] ? {1'b0, dv_q} : 65'd0);
	assign shifted = {acc_q, lo_q[63]};
	assign diff    = shifted - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						state_q <= S_RUN;
						op_q    <= req.op;
						a_q     <= a;
						b_q     <= b;
						na_q    <= sgn && a[63];
						nb_q    <= sgn && b[63];
						acc_q   <= 64'd0;
						lo_q    <= is_div ? ma : a;
						dv_q    <= is_div ? mb : b;
						cnt_q   <= 6'd63;
					end
				end
				S_RUN: begin
					if (op_q == MD_MUL || op_q == MD_MULH || op_q == MD_MULHSU
						|| op_q == MD_MULHU) begin
						acc_q <= msum[64:1];
						lo_q  <= {msum[0], lo_q[63:1]};
					end else begin
						acc_q <= diff[64] ? shifted[63:0] : diff[63:0];
						lo_q  <= {lo_q[62:0], ~diff[64]};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == S_DONE);

	always_comb begin
		unique case (op_q)
			MD_MUL:    result = lo_q;
			MD_MULH:   result = acc_q - (a_q[63] ? b_q : 64'd0) - (b_q[63] ? a_q : 64'd0);
			MD_MULHSU: result = acc_q - (a_q[63] ? b_q : 64'd0);
			MD_MULHU:  result = acc_q;
			MD_DIV:    result = (b_q == 64'd0) ? '1 : ((na_q ^ nb_q) ? 64'd0 - lo_q : lo_q);
			MD_DIVU:   result = lo_q;
			MD_REM:    result = na_q ? 64'd0 - acc_q : acc_q;
			MD_REMU:   result = acc_q;
			default:   result = lo_q;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/rv64im_execute_with_machine_csrs_core.sv */
// ============================================================================
// rv64im_execute_with_machine_csrs_core - RV64IM execute with machine CSRs
// Decodes and executes one instruction per transaction, keeps seven machine
// CSRs and hands multiply and divide to a shared bit-serial unit.
// ============================================================================
//
// Channel  Role   Transaction carries
// -------  -----  ----------------------------------------------------------
// req      sink   instruction, instr_pc, rs1_value, rs2_value, a7_value
// rsp      source rd write, next pc, memory request, status
//
// An accepted instruction is registered and executed once the output register
// is free, and its result is registered in the output register; the block
// then returns to idle and can take the next transaction.
// Multiply and divide instructions instead wait in the shared unit for its 64
// single-bit steps, and their result enters the output register when it ends.
// Reset clears the CSRs and all handshake state. The block takes no new
// transaction while one is in flight; a result waiting in the output register
// holds the execute step until the previous result has been taken.
`default_nettype none

module rv64im_execute_with_machine_csrs_core
	import rv64ex_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	rv64ex_req_if.sink   req,
	rv64ex_rsp_if.source rsp
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT} state_t;

	state_t state_q;

	// Registered instruction and operands
	logic [31:0] ins_q;
	logic [63:0] pc_q, a_q, b_q, a7_q;

	// Machine CSRs
	logic [63:0] mtvec_q, mcause_q, mstatus_q, mie_q, mepc_q, mip_q, mscratch_q;

	// Output register
	logic        out_valid_q;
	logic [4:0]  rd_index_q;
	logic        rd_write_q;
	logic [63:0] rd_value_q, next_pc_q, mem_addr_q, store_data_q;
	logic [1:0]  mem_kind_q, mem_size_q, status_q;
	logic        load_signed_q;
	logic        md_w_q;

	// Decode fields
	logic [6:0]  opc, f7;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [5:0]  shi;
	logic [11:0] csr_addr;
	logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u, link, al_z, a_sx;

	// Execute results
	logic        x_ok, x_wr, x_md, x_md_w, x_take;
	logic [63:0] x_val, x_npc, x_maddr, x_sdata, x_md_a, x_md_b;
	logic [1:0]  x_mkind, x_msize, x_status;
	logic        x_msign;
	md_op_t      x_md_op;

	// CSR side effects
	logic        csr_hit, csr_wen, do_ecall, do_mret;
	logic [63:0] csr_old, csr_src, csr_new, ms_next;

	// Multiply/divide unit
	md_req_t     md_req;
	logic        md_done;
	logic [63:0] md_result;

	logic out_free;
	logic out_set;

	assign out_free = !out_valid_q || rsp.ready;

	// A new result enters the output register from the execute step or when
	// the multiply/divide unit finishes.
	assign out_set = ((state_q == S_EXEC) && out_free && !x_md)
		|| ((state_q == S_WAIT) && md_done);

	assign opc      = ins_q[6:0];
	assign rd       = ins_q[11:7];
	assign f3       = ins_q[14:12];
	assign f7       = ins_q[31:25];
	assign shi      = ins_q[25:20];
	assign csr_addr = ins_q[31:20];
	assign imm_i    = {{52{ins_q[31]}}, ins_q[31:20]};
	assign imm_s    = {{52{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign imm_b    = {{51{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign imm_j    = {{43{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21],
		1'b0};
	assign imm_u    = {{32{ins_q[31]}}, ins_q[31:12], 12'd0};
	assign link     = pc_q + 64'd4;
	assign al_z     = {32'd0, a_q[31:0]};
	assign a_sx     = sx32(a_q);

	// Old value of the addressed CSR; a miss leaves every CSR untouched.
	always_comb begin
		csr_hit = 1'b1;
		unique case (csr_addr)
			CSR_MTVEC:    csr_old = mtvec_q;
			CSR_MCAUSE:   csr_old = mcause_q;
			CSR_MSTATUS:  csr_old = mstatus_q;
			CSR_MIE:      csr_old = mie_q;
			CSR_MEPC:     csr_old = mepc_q;
			CSR_MIP:      csr_old = mip_q;
			CSR_MSCRATCH: csr_old = mscratch_q;
			default: begin
				csr_old = 64'd0;
				csr_hit = 1'b0;
			end
		endcase
	end

	assign csr_src = f3[2] ? {59'd0, ins_q[19:15]} : a_q;

	always_comb begin
		unique case (f3[1:0])
			CSROP_RW: csr_new = csr_src;
			CSROP_RS: csr_new = csr_old | csr_src;
			CSROP_RC: csr_new = csr_old & ~csr_src;
			default:  csr_new = csr_old;
		endcase
	end

	// Main decode and combinational execute.
	always_comb begin
		x_ok     = 1'b1;
		x_wr     = 1'b0;
		x_val    = 64'd0;
		x_npc    = link;
		x_mkind  = MEM_NONE;
		x_msize  = 2'd0;
		x_msign  = 1'b0;
		x_maddr  = 64'd0;
		x_sdata  = 64'd0;
		x_status = STAT_OK;
		x_md     = 1'b0;
		x_md_w   = 1'b0;
		x_md_op  = md_op_t'(f3);
		x_md_a   = a_q;
		x_md_b   = b_q;
		x_take   = 1'b0;
		csr_wen  = 1'b0;
		do_ecall = 1'b0;
		do_mret  = 1'b0;
		unique case (opc)
			OPC_AUIPC: begin
				x_wr  = 1'b1;
				x_val = imm_u + pc_q;
			end
			OPC_LUI: begin
				x_wr  = 1'b1;
				x_val = imm_u;
			end
			OPC_OP: begin
				x_wr = 1'b1;
				if (f7 == F7_BASE) begin
					unique case (f3)
						3'd0: x_val = a_q + b_q;
						3'd1: x_val = a_q << b_q[5:0];
						3'd2: x_val = {63'd0, $signed(a_q) < $signed(b_q)};
						3'd3: x_val = {63'd0, a_q < b_q};
						3'd4: x_val = a_q ^ b_q;
						3'd5: x_val = a_q >> b_q[5:0];
						3'd6: x_val = a_q | b_q;
						default: x_val = a_q & b_q;
					endcase
				end else if (f7 == F7_ALT && f3 == 3'd0) begin
					x_val = a_q - b_q;
				end else if (f7 == F7_ALT && f3 == 3'd5) begin
					x_val = $unsigned($signed(a_q) >>> b_q[5:0]);
				end else if (f7 == F7_MULDIV) begin
					x_md = 1'b1;
				end else begin
					x_ok = 1'b0;
				end
			end
			OPC_OP32: begin
				x_wr = 1'b1;
				if (f7 == F7_BASE && f3 == 3'd0) begin
					x_val = sx32(a_q + b_q);
				end else if (f7 == F7_BASE && f3 == 3'd1) begin
					x_val = sx32(a_q << b_q[4:0]);
				end else if (f7 == F7_BASE && f3 == 3'd5) begin
					x_val = sx32(al_z >> b_q[4:0]);
				end else if (f7 == F7_ALT && f3 == 3'd0) begin
					x_val = sx32(a_q - b_q);
				end else if (f7 == F7_ALT && f3 == 3'd5) begin
					x_val = sx32($unsigned($signed(a_sx) >>> b_q[4:0]));
				end else if (f7 == F7_MULDIV && (f3 == 3'd0 || f3[2])) begin
					x_md   = 1'b1;
					x_md_w = 1'b1;
					if (f3[2]) begin
						// Word divides work on 32-bit operands, extended to 64 bits.
						x_md_a = f3[0] ? al_z : a_sx;
						x_md_b = f3[0] ? {32'd0, b_q[31:0]} : sx32(b_q);
					end
				end else begin
					x_ok = 1'b0;
				end
			end
			OPC_LOAD: begin
				if (f3 == 3'd7) begin
					x_ok = 1'b0;
				end else begin
					x_wr    = 1'b1;
					x_mkind = MEM_LOAD;
					x_msize = f3[1:0];
					x_msign = !f3[2];
					x_maddr = a_q + imm_i;
				end
			end
			OPC_OPIMM: begin
				x_wr = 1'b1;
				unique case (f3)
					3'd0: x_val = a_q + imm_i;
					3'd2: x_val = {63'd0, $signed(a_q) < $signed(imm_i)};
					3'd3: x_val = {63'd0, a_q < imm_i};
					3'd4: x_val = a_q ^ imm_i;
					3'd6: x_val = a_q | imm_i;
					3'd7: x_val = a_q & imm_i;
					3'd1: begin
						if (ins_q[31:26] == 6'd0) x_val = a_q << shi;
						else x_ok = 1'b0;
					end
					default: begin
						if (ins_q[31:26] == 6'd0) x_val = a_q >> shi;
						else if (ins_q[31:26] == 6'h10) x_val = $unsigned($signed(a_q) >>> shi);
						else x_ok = 1'b0;
					end
				endcase
			end
			OPC_OPIMM32: begin
				x_wr = 1'b1;
				if (f3 == 3'd0) x_val = sx32(a_q + imm_i);
				else if (f3 == 3'd1 && f7 == F7_BASE) x_val = sx32(a_q << shi[4:0]);
				else if (f3 == 3'd5 && f7 == F7_BASE) x_val = sx32(al_z >> shi[4:0]);
				else if (f3 == 3'd5 && f7 == F7_ALT)
					x_val = sx32($unsigned($signed(a_sx) >>> shi[4:0]));
				else x_ok = 1'b0;
			end
			OPC_JALR: begin
				if (f3 != 3'd0) begin
					x_ok = 1'b0;
				end else begin
					x_wr  = 1'b1;
					x_val = link;
					x_npc = (a_q + imm_i) & ~64'd1;
				end
			end
			OPC_STORE: begin
				if (f3[2]) begin
					x_ok = 1'b0;
				end else begin
					x_mkind = MEM_STORE;
					x_msize = f3[1:0];
					x_maddr = a_q + imm_s;
					unique case (f3[1:0])
						2'd0: x_sdata = {56'd0, b_q[7:0]};
						2'd1: x_sdata = {48'd0, b_q[15:0]};
						2'd2: x_sdata = {32'd0, b_q[31:0]};
						default: x_sdata = b_q;
					endcase
				end
			end
			OPC_BRANCH: begin
				unique case (f3)
					3'd0: x_take = (a_q == b_q);
					3'd1: x_take = (a_q != b_q);
					3'd4: x_take = $signed(a_q) < $signed(b_q);
					3'd5: x_take = !($signed(a_q) < $signed(b_q));
					3'd6: x_take = a_q < b_q;
					3'd7: x_take = a_q >= b_q;
					default: x_ok = 1'b0;
				endcase
				if (x_take) x_npc = pc_q + imm_b;
			end
			OPC_JAL: begin
				x_wr  = 1'b1;
				x_val = link;
				x_npc = pc_q + imm_j;
			end
			OPC_SYSTEM: begin
				if (ins_q == WORD_EBREAK) begin
					x_status = STAT_EBREAK;
				end else if (ins_q == WORD_ECALL) begin
					do_ecall = 1'b1;
					x_npc    = mtvec_q;
					x_status = STAT_ECALL;
				end else if (ins_q == WORD_MRET) begin
					do_mret = 1'b1;
					x_npc   = mepc_q;
				end else if (f3[1:0] != 2'd0) begin
					if (csr_hit) begin
						csr_wen = 1'b1;
						x_wr    = 1'b1;
						x_val   = csr_old;
					end
				end else begin
					x_ok = 1'b0;
				end
			end
			OPC_CUSTOM3: begin
			end
			OPC_FENCE: begin
				if (ins_q != WORD_FENCE_I) x_ok = 1'b0;
			end
			OPC_BRKALT: begin
				x_status = STAT_EBREAK;
			end
			default: begin
				x_ok = 1'b0;
			end
		endcase
		if (!x_ok) begin
			x_wr     = 1'b0;
			x_md     = 1'b0;
			x_npc    = link;
			x_status = STAT_ILLEGAL;
			x_mkind  = MEM_NONE;
			x_msize  = 2'd0;
			x_msign  = 1'b0;
			x_maddr  = 64'd0;
			x_sdata  = 64'd0;
		end
		if (rd == 5'd0) x_wr = 1'b0;
		if (!x_wr) x_val = 64'd0;
	end

	// Next mstatus before the keep mask, which is applied on every instruction.
	always_comb begin
		ms_next = mstatus_q;
		if (do_ecall) begin
			ms_next = mstatus_q | ST_MPP_SET;
		end else if (do_mret) begin
			ms_next[ST_MIE_BIT]  = mstatus_q[ST_MPIE_BIT];
			ms_next[ST_MPIE_BIT] = 1'b1;
			ms_next              = ms_next & ST_MPP_CLEAR;
		end else if (csr_wen && csr_addr == CSR_MSTATUS) begin
			ms_next = csr_new;
		end
	end

	assign md_req.start = (state_q == S_EXEC) && out_free && x_md;
	assign md_req.op    = x_md_op;

	rv64ex_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (x_md_a),
		.b      (x_md_b),
		.done   (md_done),
		.result (md_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mtvec_q     <= 64'd0;
			mcause_q    <= 64'd0;
			mstatus_q   <= 64'd0;
			mie_q       <= 64'd0;
			mepc_q      <= 64'd0;
			mip_q       <= 64'd0;
			mscratch_q  <= 64'd0;
		end else begin
			if (out_set) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						ins_q   <= req.instruction;
						pc_q    <= req.instr_pc;
						a_q     <= req.rs1_value;
						b_q     <= req.rs2_value;
						a7_q    <= req.a7_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						rd_index_q    <= rd;
						rd_write_q    <= x_wr;
						rd_value_q    <= x_val;
						next_pc_q     <= x_npc;
						mem_kind_q    <= x_mkind;
						mem_size_q    <= x_msize;
						load_signed_q <= x_msign;
						mem_addr_q    <= x_maddr;
						store_data_q  <= x_sdata;
						status_q      <= x_status;
						md_w_q        <= x_md_w;
						mstatus_q     <= ms_next & ST_KEEP_MASK;
						if (do_ecall) begin
							mepc_q   <= pc_q;
							mcause_q <= a7_q;
						end
						if (csr_wen) begin
							unique case (csr_addr)
								CSR_MTVEC:    mtvec_q    <= csr_new;
								CSR_MCAUSE:   mcause_q   <= csr_new;
								CSR_MEPC:     mepc_q     <= csr_new;
								CSR_MIE:      mie_q      <= csr_new;
								CSR_MIP:      mip_q      <= csr_new;
								CSR_MSCRATCH: mscratch_q <= csr_new;
								default: begin
								end
							endcase
						end
						if (x_md) begin
							state_q <= S_WAIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_WAIT: begin
					if (md_done) begin
						if (rd_write_q) rd_value_q <= md_w_q ? sx32(md_result) : md_result;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.rd_index      = rd_index_q;
	assign rsp.rd_write      = rd_write_q;
	assign rsp.rd_value      = rd_value_q;
	assign rsp.next_pc       = next_pc_q;
	assign rsp.mem_kind      = mem_kind_q;
	assign rsp.mem_size_log2 = mem_size_q;
	assign rsp.load_signed   = load_signed_q;
	assign rsp.mem_addr      = mem_addr_q;
	assign rsp.store_data    = store_data_q;
	assign rsp.status        = status_q;

	// Once a transaction is taken, the block is busy and takes no second one back to back.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("accepted a second transaction back to back");

	// The multiply/divide unit only finishes while the sequencer waits for it.
	a_md_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == S_WAIT)
		else $error("multiply/divide result arrived outside the wait state");

	// x0 is never written.
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.rd_write && rsp.rd_index == 5'd0))
		else $error("result writes register x0");

endmodule

`default_nettype wire

/* sim/rv64im_execute_with_machine_csrs_core_test.sv */
// ----------------------------------------------------------------------------
// RV64IM execute block testbench
// Drives instruction transactions into the execute block, predicts every
// result with a behavioural model of the decoder and the machine CSRs, and
// compares each result transaction field by field against its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rv64im_execute_with_machine_csrs_core_test;
	import rv64ex_pkg::*;

	localparam int unsigned HALF_PERIOD   = 6;
	localparam int unsigned RANDOM_ITEMS  = 950;
	localparam int unsigned QUIET_ITEMS   = 150;
	localparam int unsigned STALL_LIMIT   = 20000;
	localparam int unsigned DRAIN_CYCLES  = 200;
	localparam int unsigned LONG_HOLD     = 400;

	// One expected result, laid out as the result channel carries it.
	typedef struct {
		logic [4:0]  rd_index;
		logic        rd_write;
		logic [63:0] rd_value;
		logic [63:0] next_pc;
		logic [1:0]  mem_kind;
		logic [1:0]  mem_size_log2;
		logic        load_signed;
		logic [63:0] mem_addr;
		logic [63:0] store_data;
		logic [1:0]  status;
	} exec_result_t;

	// A directed row: the instruction and its operands, plus an optional
	// result typed in by hand where it is plain to see.
	typedef struct {
		logic [31:0] word;
		logic [63:0] pc;
		logic [63:0] src1;
		logic [63:0] src2;
		logic [63:0] cause;
		bit          fixed;
		exec_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	rv64ex_req_if req ();
	rv64ex_rsp_if rsp ();

	rv64im_execute_with_machine_csrs_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Predictor's private copy of the machine CSRs.
	logic [63:0] m_tvec, m_cause, m_status, m_ie, m_epc, m_ip, m_scratch;

	exec_result_t pending_results[$];
	exec_result_t typed_results[$];
	bit           typed_flags[$];

	int unsigned  mismatches;
	int unsigned  accepted_in;
	int unsigned  accepted_out;
	int unsigned  quiet_cycles;
	bit           no_idle;
	bit           hold_rsp;
	bit           timed_out;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------------
	// Reference arithmetic helpers
	// ------------------------------------------------------------------------
	function automatic logic [63:0] sext32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic logic [63:0] quot_signed(input logic [63:0] a, input logic [63:0] b,
		input bit want_rem);
		logic [63:0] ma, mb, q, r;
		if (b == 64'd0) return want_rem ? a : '1;
		if (a == 64'h8000_0000_0000_0000 && b == '1) return want_rem ? 64'd0 : a;
		ma = a[63] ? -a : a;
		mb = b[63] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (want_rem) return a[63] ? -r : r;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic logic [63:0] quot_unsigned(input logic [63:0] a, input logic [63:0] b,
		input bit want_rem);
		if (b == 64'd0) return want_rem ? a : '1;
		return want_rem ? a % b : a / b;
	endfunction

	// Register-register ALU, 64-bit forms. Returns 0 when the encoding is illegal.
	function automatic bit alu_reg(input logic [6:0] f7, input logic [2:0] f3,
		input logic [63:0] a, input logic [63:0] b, output logic [63:0] v);
		logic [127:0] pu, ps, psu;
		v = '0;
		pu  = {64'd0, a} * {64'd0, b};
		ps  = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		psu = {{64{a[63]}}, a} * {64'd0, b};
		if (f7 == F7_BASE) begin
			case (f3)
				3'd0: v = a + b;
				3'd1: v = a << b[5:0];
				3'd2: v = {63'd0, $signed(a) < $signed(b)};
				3'd3: v = {63'd0, a < b};
				3'd4: v = a ^ b;
				3'd5: v = a >> b[5:0];
				3'd6: v = a | b;
				default: v = a & b;
			endcase
			return 1'b1;
		end
		if (f7 == F7_ALT) begin
			if (f3 == 3'd0) begin v = a - b; return 1'b1; end
			if (f3 == 3'd5) begin v = $signed(a) >>> b[5:0]; return 1'b1; end
			return 1'b0;
		end
		if (f7 == F7_MULDIV) begin
			case (md_op_t'(f3))
				MD_MUL:    v = pu[63:0];
				MD_MULH:   v = ps[127:64];
				MD_MULHSU: v = psu[127:64];
				MD_MULHU:  v = pu[127:64];
				MD_DIV:    v = quot_signed(a, b, 1'b0);
				MD_DIVU:   v = quot_unsigned(a, b, 1'b0);
				MD_REM:    v = quot_signed(a, b, 1'b1);
				default:   v = quot_unsigned(a, b, 1'b1);
			endcase
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Register-register ALU, word forms.
	function automatic bit alu_word(input logic [6:0] f7, input logic [2:0] f3,
		input logic [63:0] a, input logic [63:0] b, output logic [63:0] v);
		logic [63:0] al, bl;
		logic [31:0] t;
		v = '0;
		al = {32'd0, a[31:0]};
		bl = {32'd0, b[31:0]};
		if (f7 == F7_BASE) begin
			if (f3 == 3'd0) begin v = sext32(a + b); return 1'b1; end
			if (f3 == 3'd1) begin v = sext32(a << b[4:0]); return 1'b1; end
			if (f3 == 3'd5) begin v = sext32(al >> b[4:0]); return 1'b1; end
			return 1'b0;
		end
		if (f7 == F7_ALT) begin
			if (f3 == 3'd0) begin v = sext32(a - b); return 1'b1; end
			if (f3 == 3'd5) begin
				t = $signed(a[31:0]) >>> b[4:0];
				v = sext32({32'd0, t});
				return 1'b1;
			end
			return 1'b0;
		end
		if (f7 == F7_MULDIV) begin
			case (md_op_t'(f3))
				MD_MUL:  v = sext32(a * b);
				MD_DIV:  v = sext32(quot_signed(sext32(al), sext32(bl), 1'b0));
				MD_DIVU: v = sext32(quot_unsigned(al, bl, 1'b0));
				MD_REM:  v = sext32(quot_signed(sext32(al), sext32(bl), 1'b1));
				MD_REMU: v = sext32(quot_unsigned(al, bl, 1'b1));
				default: return 1'b0;
			endcase
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Predict one instruction, updating the CSR copy as the block would.
	// ------------------------------------------------------------------------
	function automatic exec_result_t execute_word(input logic [31:0] ins, input logic [63:0] pc,
		input logic [63:0] a, input logic [63:0] b, input logic [63:0] a7);
		exec_result_t r;
		logic [6:0]  opc, f7;
		logic [2:0]  f3;
		logic [4:0]  rd;
		logic [5:0]  shi;
		logic [63:0] imm_i, imm_s, imm_b, imm_j, link, val, npc, src, old;
		logic [63:0] t;
		logic [31:0] t32;
		bit wr, ok, take, hit;
		opc = ins[6:0];
		rd = ins[11:7];
		f3 = ins[14:12];
		f7 = ins[31:25];
		shi = ins[25:20];
		imm_i = {{52{ins[31]}}, ins[31:20]};
		imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
		imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
		imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
		link = pc + 64'd4;
		wr = 1'b0; ok = 1'b1; val = '0; npc = link;
		r = '{default: '0};
		case (opc)
			OPC_AUIPC: begin wr = 1'b1; val = sext32({32'd0, ins[31:12], 12'd0}) + pc; end
			OPC_LUI:   begin wr = 1'b1; val = sext32({32'd0, ins[31:12], 12'd0}); end
			OPC_OP:    begin ok = alu_reg(f7, f3, a, b, val); wr = ok; end
			OPC_OP32:  begin ok = alu_word(f7, f3, a, b, val); wr = ok; end
			OPC_LOAD: begin
				if (f3 == 3'd7) ok = 1'b0;
				else begin
					wr = 1'b1;
					r.mem_kind = MEM_LOAD;
					r.mem_size_log2 = f3[1:0];
					r.load_signed = ~f3[2];
					r.mem_addr = a + imm_i;
				end
			end
			OPC_OPIMM: begin
				wr = 1'b1;
				case (f3)
					3'd0: val = a + imm_i;
					3'd2: val = {63'd0, $signed(a) < $signed(imm_i)};
					3'd3: val = {63'd0, a < imm_i};
					3'd4: val = a ^ imm_i;
					3'd6: val = a | imm_i;
					3'd7: val = a & imm_i;
					3'd1: if (f7[6:1] == 6'd0) val = a << shi; else ok = 1'b0;
					default: begin
						if (f7[6:1] == 6'd0) val = a >> shi;
						else if (f7[6:1] == 6'h10) val = $signed(a) >>> shi;
						else ok = 1'b0;
					end
				endcase
				if (!ok) wr = 1'b0;
			end
			OPC_OPIMM32: begin
				wr = 1'b1;
				if (f3 == 3'd0) val = sext32(a + imm_i);
				else if (f3 == 3'd1 && f7 == F7_BASE) val = sext32(a << shi[4:0]);
				else if (f3 == 3'd5 && f7 == F7_BASE) val = sext32({32'd0, a[31:0]} >> shi[4:0]);
				else if (f3 == 3'd5 && f7 == F7_ALT) begin
					t32 = $signed(a[31:0]) >>> shi[4:0];
					val = sext32({32'd0, t32});
				end else begin ok = 1'b0; wr = 1'b0; end
			end
			OPC_JALR: begin
				if (f3 != 3'd0) ok = 1'b0;
				else begin
					wr = 1'b1; val = link;
					t = a + imm_i;
					npc = {t[63:1], 1'b0};
				end
			end
			OPC_STORE: begin
				if (f3 > 3'd3) ok = 1'b0;
				else begin
					r.mem_kind = MEM_STORE;
					r.mem_size_log2 = f3[1:0];
					r.mem_addr = a + imm_s;
					case (f3[1:0])
						2'd0: r.store_data = {56'd0, b[7:0]};
						2'd1: r.store_data = {48'd0, b[15:0]};
						2'd2: r.store_data = {32'd0, b[31:0]};
						default: r.store_data = b;
					endcase
				end
			end
			OPC_BRANCH: begin
				take = 1'b0;
				case (f3)
					3'd0: take = (a == b);
					3'd1: take = (a != b);
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: ok = 1'b0;
				endcase
				if (take) npc = pc + imm_b;
			end
			OPC_JAL: begin wr = 1'b1; val = link; npc = pc + imm_j; end
			OPC_SYSTEM: begin
				if (ins == WORD_EBREAK) r.status = STAT_EBREAK;
				else if (ins == WORD_ECALL) begin
					m_epc = pc;
					m_cause = a7;
					npc = m_tvec;
					m_status |= ST_MPP_SET;
					r.status = STAT_ECALL;
				end else if (ins == WORD_MRET) begin
					npc = m_epc;
					m_status[ST_MIE_BIT] = m_status[ST_MPIE_BIT];
					m_status[ST_MPIE_BIT] = 1'b1;
					m_status &= ST_MPP_CLEAR;
				end else if (f3[1:0] != 2'd0) begin
					src = f3[2] ? {59'd0, ins[19:15]} : a;
					hit = 1'b1;
					case (ins[31:20])
						CSR_MTVEC:    old = m_tvec;
						CSR_MCAUSE:   old = m_cause;
						CSR_MSTATUS:  old = m_status;
						CSR_MIE:      old = m_ie;
						CSR_MEPC:     old = m_epc;
						CSR_MIP:      old = m_ip;
						CSR_MSCRATCH: old = m_scratch;
						default: begin hit = 1'b0; old = '0; end
					endcase
					if (hit) begin
						case (f3[1:0])
							CSROP_RW: t = src;
							CSROP_RS: t = old | src;
							default:  t = old & ~src;
						endcase
						case (ins[31:20])
							CSR_MTVEC:    m_tvec = t;
							CSR_MCAUSE:   m_cause = t;
							CSR_MSTATUS:  m_status = t;
							CSR_MIE:      m_ie = t;
							CSR_MEPC:     m_epc = t;
							CSR_MIP:      m_ip = t;
							default:      m_scratch = t;
						endcase
						wr = 1'b1; val = old;
					end
				end else ok = 1'b0;
			end
			OPC_CUSTOM3: ;
			OPC_FENCE:  if (ins != WORD_FENCE_I) ok = 1'b0;
			OPC_BRKALT: r.status = STAT_EBREAK;
			default: ok = 1'b0;
		endcase
		if (!ok) begin
			wr = 1'b0; val = '0; npc = link;
			r = '{default: '0};
			r.status = STAT_ILLEGAL;
		end
		if (rd == 5'd0) wr = 1'b0;
		if (!wr) val = '0;
		m_status &= ST_KEEP_MASK;
		r.rd_index = rd;
		r.rd_write = wr;
		r.rd_value = val;
		r.next_pc = npc;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatches++;
		$display("mismatch on result %0d: %s got %h expected %h", accepted_out, what, got, want);
	endtask

	task automatic compare_result(input exec_result_t want);
		if (rsp.rd_index !== want.rd_index) report_mismatch("rd_index", rsp.rd_index, want.rd_index);
		if (rsp.rd_write !== want.rd_write) report_mismatch("rd_write", rsp.rd_write, want.rd_write);
		if (rsp.rd_value !== want.rd_value) report_mismatch("rd_value", rsp.rd_value, want.rd_value);
		if (rsp.next_pc !== want.next_pc) report_mismatch("next_pc", rsp.next_pc, want.next_pc);
		if (rsp.mem_kind !== want.mem_kind) report_mismatch("mem_kind", rsp.mem_kind, want.mem_kind);
		if (rsp.mem_size_log2 !== want.mem_size_log2)
			report_mismatch("mem_size_log2", rsp.mem_size_log2, want.mem_size_log2);
		if (rsp.load_signed !== want.load_signed)
			report_mismatch("load_signed", rsp.load_signed, want.load_signed);
		if (rsp.mem_addr !== want.mem_addr) report_mismatch("mem_addr", rsp.mem_addr, want.mem_addr);
		if (rsp.store_data !== want.store_data)
			report_mismatch("store_data", rsp.store_data, want.store_data);
		if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
	endtask

	// ------------------------------------------------------------------------
	// Result side: random ready bursts, an occasional long hold, and the
	// check of every accepted result against the oldest expectation.
	// ------------------------------------------------------------------------
	initial begin
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, rd_index", {59'd0, rsp.rd_index}, 64'd0);
			end else begin
				compare_result(pending_results.pop_front());
				if (typed_flags.pop_front()) compare_result(typed_results.pop_front());
			end
			accepted_out++;
		end
	end

	initial begin : result_ready_driver
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
			end else if (no_idle || $urandom_range(0, 3) != 0) begin
				rsp.ready <= 1'b1;
			end else begin
				gap = $urandom_range(1, 15);
				rsp.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end
		end
	end

	// Watchdog: counts cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Instruction side
	// ------------------------------------------------------------------------

	// Offer one instruction and wait until the block takes it. The predictor
	// runs at acceptance, in order, so CSR state follows the block exactly.
	task automatic send_word(input logic [31:0] ins, input logic [63:0] pc, input logic [63:0] a,
		input logic [63:0] b, input logic [63:0] a7, input bit fixed, input exec_result_t hand);
		int unsigned gap;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.instruction <= ins;
		req.instr_pc <= pc;
		req.rs1_value <= a;
		req.rs2_value <= b;
		req.a7_value <= a7;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(execute_word(ins, pc, a, b, a7));
		typed_flags.push_back(fixed);
		if (fixed) typed_results.push_back(hand);
		accepted_in++;
	endtask

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = 64'h8000_0000_0000_0000;
			3: v = 64'h7FFF_FFFF_FFFF_FFFF;
			4: v = {{32{$urandom_range(0, 1) == 1}}, $urandom()};
			5: v = $urandom_range(0, 70);
			default: v = {$urandom(), $urandom()};
		endcase
		return v;
	endfunction

	// Builds an instruction of a random class with random fields, which may leave it illegal.
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		logic [11:0] csrs[7];
		csrs = '{CSR_MTVEC, CSR_MCAUSE, CSR_MSTATUS, CSR_MIE, CSR_MEPC, CSR_MIP, CSR_MSCRATCH};
		w = $urandom();
		case ($urandom_range(0, 19))
			0:  w[6:0] = OPC_AUIPC;
			1:  w[6:0] = OPC_LUI;
			2, 3: begin w[6:0] = OPC_OP; w[31:25] = $urandom_range(0, 1) ? F7_BASE : F7_ALT; end
			4:  begin
				// Multiply and divide are slow; keep them to a modest share.
				w[6:0] = OPC_OP; w[31:25] = F7_MULDIV;
			end
			5:  begin
				w[6:0] = OPC_OP32;
				case ($urandom_range(0, 2))
					0: w[31:25] = F7_BASE;
					1: w[31:25] = F7_ALT;
					default: w[31:25] = F7_MULDIV;
				endcase
			end
			6:  w[6:0] = OPC_LOAD;
			7, 8: begin
				w[6:0] = OPC_OPIMM;
				if ($urandom_range(0, 1)) w[31:26] = $urandom_range(0, 1) ? 6'h00 : 6'h10;
			end
			9:  begin
				w[6:0] = OPC_OPIMM32;
				if ($urandom_range(0, 1)) w[31:25] = $urandom_range(0, 1) ? F7_BASE : F7_ALT;
			end
			10: begin w[6:0] = OPC_JALR; if ($urandom_range(0, 3)) w[14:12] = 3'd0; end
			11: w[6:0] = OPC_STORE;
			12: w[6:0] = OPC_BRANCH;
			13: w[6:0] = OPC_JAL;
			14, 15: begin
				w[6:0] = OPC_SYSTEM;
				if ($urandom_range(0, 7)) w[31:20] = csrs[$urandom_range(0, 6)];
			end
			16: case ($urandom_range(0, 3))
				0: w = WORD_ECALL;
				1: w = WORD_MRET;
				2: w = WORD_EBREAK;
				default: w = WORD_FENCE_I;
			endcase
			17: w[6:0] = ($urandom_range(0, 1)) ? OPC_CUSTOM3 : OPC_BRKALT;
			18: w[6:0] = OPC_FENCE;
			default: ;
		endcase
		return w;
	endfunction

	// Directed table. Rows with fixed results follow straight from reset:
	// mtvec and mepc are still zero, so mret and ecall land on zero.
	stim_row_t plan[$];

	function automatic exec_result_t plain_result(input logic [4:0] rd, input logic [63:0] npc,
		input logic [1:0] st);
		exec_result_t r;
		r = '{default: '0};
		r.rd_index = rd;
		r.next_pc = npc;
		r.status = st;
		return r;
	endfunction

	task automatic add_row(input logic [31:0] w, input logic [63:0] pc, input logic [63:0] a,
		input logic [63:0] b, input logic [63:0] a7, input bit fixed, input exec_result_t res);
		stim_row_t row;
		row.word = w; row.pc = pc; row.src1 = a; row.src2 = b; row.cause = a7;
		row.fixed = fixed; row.res = res;
		plan.push_back(row);
	endtask

	task automatic build_plan();
		exec_result_t none, r;
		none = '{default: '0};
		// Reading mstatus right after reset gives zero.
		r = plain_result(5'd5, 64'h104, STAT_OK); r.rd_write = 1'b1;
		add_row({CSR_MSTATUS, 5'd0, 3'd2, 5'd5, OPC_SYSTEM}, 64'h100, '1, '0, '0, 1'b1, r);
		// mret with mepc still zero.
		add_row(WORD_MRET, 64'h200, '0, '0, '0, 1'b1, plain_result(5'd0, 64'd0, STAT_OK));
		// ecall with a zero trap vector.
		add_row(WORD_ECALL, '1, '0, '0, '1, 1'b1, plain_result(5'd0, 64'd0, STAT_ECALL));
		add_row(WORD_EBREAK, '1, '0, '0, '0, 1'b1, plain_result(5'd0, 64'd3, STAT_EBREAK));
		add_row(32'hFFFF_FFEB, 64'h10, '1, '1, '1, 1'b1,
			plain_result(5'd31, 64'h14, STAT_EBREAK));
		// All-zero and all-ones words are illegal.
		add_row(32'h0000_0000, 64'h40, '1, '1, '0, 1'b1, plain_result(5'd0, 64'h44, STAT_ILLEGAL));
		add_row(32'hFFFF_FFFF, 64'h40, '1, '1, '0, 1'b1, plain_result(5'd31, 64'h44, STAT_ILLEGAL));
		// Load with funct3 seven and a bad slliw are illegal as well.
		add_row({12'h7FF, 5'd1, 3'd7, 5'd3, OPC_LOAD}, 64'h0, '1, '0, '0, 1'b1,
			plain_result(5'd3, 64'h4, STAT_ILLEGAL));
		add_row({7'h40, 5'd3, 5'd1, 3'd1, 5'd2, OPC_OPIMM32}, 64'h0, '1, '0, '0, 1'b1,
			plain_result(5'd2, 64'h4, STAT_ILLEGAL));
		add_row({7'd0, 5'd0, 5'd0, 3'd0, 5'd0, OPC_CUSTOM3}, 64'h8, '1, '1, '0, 1'b1,
			plain_result(5'd0, 64'hC, STAT_OK));
		add_row(WORD_FENCE_I, '1, '0, '0, '0, 1'b1, plain_result(5'd0, 64'd3, STAT_OK));
		// Predictor-checked rows: CSR writes and a miss, a trap round trip, divide corners, mulh and sra.
		add_row({CSR_MTVEC, 5'd1, 3'd1, 5'd4, OPC_SYSTEM}, 64'h300, 64'h8000_0000, '0, '0, 0, none);
		add_row({CSR_MSTATUS, 5'd1, 3'd1, 5'd4, OPC_SYSTEM}, 64'h304, '1, '0, '0, 0, none);
		add_row({CSR_MSTATUS, 5'h1F, 3'd7, 5'd4, OPC_SYSTEM}, 64'h308, '0, '0, '0, 0, none);
		add_row({CSR_MSCRATCH, 5'h1F, 3'd6, 5'd6, OPC_SYSTEM}, 64'h30C, '0, '0, '0, 0, none);
		add_row({12'h7C0, 5'd1, 3'd1, 5'd7, OPC_SYSTEM}, 64'h310, '1, '0, '0, 0, none);
		add_row(WORD_ECALL, 64'h400, '0, '0, 64'h0B, 0, none);
		add_row({CSR_MEPC, 5'd0, 3'd2, 5'd8, OPC_SYSTEM}, 64'h404, '0, '0, '0, 0, none);
		add_row(WORD_MRET, 64'h408, '0, '0, '0, 0, none);
		add_row({F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd9, OPC_OP}, 64'h0,
			64'h8000_0000_0000_0000, '1, '0, 0, none);
		add_row({F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd9, OPC_OP}, 64'h0,
			64'h8000_0000_0000_0000, '1, '0, 0, none);
		add_row({F7_MULDIV, 5'd2, 5'd1, 3'd5, 5'd9, OPC_OP}, 64'h0, '1, '0, '0, 0, none);
		add_row({F7_MULDIV, 5'd2, 5'd1, 3'd7, 5'd9, OPC_OP32}, 64'h0, '1, '0, '0, 0, none);
		add_row({F7_MULDIV, 5'd2, 5'd1, 3'd1, 5'd9, OPC_OP}, 64'h0, '1, '1, '0, 0, none);
		add_row({F7_ALT, 5'd2, 5'd1, 3'd5, 5'd9, OPC_OP}, 64'h0,
			64'h8000_0000_0000_0000, 64'hFF, '0, 0, none);
	endtask

	initial begin : main_sequence
		exec_result_t none;
		int unsigned n;
		none = '{default: '0};
		mismatches = 0;
		accepted_in = 0;
		accepted_out = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		hold_rsp = 1'b0;
		m_tvec = '0; m_cause = '0; m_status = '0; m_ie = '0;
		m_epc = '0; m_ip = '0; m_scratch = '0;
		req.valid = 1'b0;
		req.instruction = '0;
		req.instr_pc = '0;
		req.rs1_value = '0;
		req.rs2_value = '0;
		req.a7_value = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_plan();
		foreach (plan[i])
			send_word(plan[i].word, plan[i].pc, plan[i].src1, plan[i].src2, plan[i].cause,
				plan[i].fixed, plan[i].res);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// Long receiver hold while the sender keeps offering; the release
			// is timed in its own process since the sender soon stalls.
			if (n == 200) begin
				hold_rsp = 1'b1;
				fork
					begin
						repeat (LONG_HOLD) @(posedge clk);
						hold_rsp = 1'b0;
					end
				join_none
			end
			// Sender pause until everything outstanding has come back.
			if (n == 500) begin
				req.valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			if (n == RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;
			send_word($urandom_range(0, 15) == 0 ? $urandom() : rand_word(),
				rand64(), rand64(), rand64(), rand64(), 1'b0, none);
		end
		req.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d instructions sent, %0d results checked, %0d mismatches",
			accepted_in, accepted_out, mismatches);
		$display("covered all opcode classes, CSR traps, divide corners and stalls");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
